// File: rtl/dlfd_pkg.sv
// Shared types, constants and helper functions for the dual-lane FNV digest.
// No dependencies; every other file in this block but dlfd_chk imports it.
package dlfd_pkg;

    // Lane bases and per-byte multipliers
    localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;
    localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
    localparam logic [63:0] SEC_BASIS = 64'd9241386435364257181;
    localparam logic [63:0] SEC_MULT  = 64'h880355F21E6D1965;

    // Finalizer constants (splitmix64)
    localparam logic [63:0] GOLD_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_K1     = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_K2     = 64'h94D049BB133111EB;
    localparam int unsigned MIX_S1     = 30;
    localparam int unsigned MIX_S2     = 27;
    localparam int unsigned MIX_S3     = 31;

    // One classified input item, as held in the queue
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } t_item;

    // Request to the shared 64-bit multiplier
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    // Response from the shared 64-bit multiplier
    typedef struct packed {
        logic        done;
        logic [63:0] prod;
    } t_mul_rsp;

    function automatic logic [63:0] xor_shr(input logic [63:0] x, input int unsigned sh);
        return x ^ (x >> sh);
    endfunction

endpackage

// File: rtl/dlfd_front.sv
// Input side: accepts stream transactions, drops idle items, queues the rest.
// Depends on dlfd_pkg.
module dlfd_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dlfd_pkg::t_item i_item,
    output logic           o_head_valid,
    output dlfd_pkg::t_item o_head,
    input  logic           i_pop
);
    import dlfd_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_count;
    logic           push;
    logic           pop;

    assign o_ready      = (r_count != CW'(QUEUE_DEPTH));
    // an item with neither a byte nor the last mark does nothing: drop it here
    assign push         = i_valid && o_ready && (i_item.has_byte || i_item.last);
    assign o_head_valid = (r_count != '0);
    assign pop          = i_pop && o_head_valid;
    assign o_head       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/dlfd_mul.sv
// Iterative 64x64 multiplier, low 64 bits of the product, on one 32x32 unit.
// Depends on dlfd_pkg. Result is valid for one cycle, marked by done.
module dlfd_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dlfd_pkg::t_mul_req i_req,
    output dlfd_pkg::t_mul_rsp o_rsp
);
    import dlfd_pkg::*;

    logic        r_busy;
    logic [1:0]  r_step;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [31:0] ma;
    logic [31:0] mb;

    // partial products: lo*lo, lo*hi, hi*lo (hi*hi falls outside 64 bits)
    always_comb begin
        case (r_step)
            2'd0:    begin ma = r_a[31:0];  mb = r_b[31:0];  end
            2'd1:    begin ma = r_a[31:0];  mb = r_b[63:32]; end
            default: begin ma = r_a[63:32]; mb = r_b[31:0];  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_step <= '0;
            r_a    <= i_req.a;
            r_b    <= i_req.b;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            r_prod <= ma * mb;
            if (r_step == 2'd1) begin
                r_acc <= r_prod;
            end else if (r_step == 2'd2) begin
                r_acc <= r_acc + {r_prod[31:0], 32'd0};
            end
            if (r_step == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_rsp.done = r_busy && (r_step == 2'd3);
    assign o_rsp.prod = r_acc + {r_prod[31:0], 32'd0};

endmodule

// File: rtl/dlfd_back.sv
// Execution side: lane updates, finalizer sequence and the output register.
// Depends on dlfd_pkg; drives the shared multiplier in dlfd_mul.
module dlfd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  dlfd_pkg::t_item    i_head,
    output logic               o_pop,
    output dlfd_pkg::t_mul_req o_req,
    input  dlfd_pkg::t_mul_rsp i_rsp,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [127:0]       o_data
);
    import dlfd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SEC, S_FNV, S_GAM, S_H1, S_H2, S_L1, S_L2, S_OUT
    } t_state;

    t_state      r_state;
    t_mul_req    r_req;
    logic [63:0] r_fnv;
    logic [63:0] r_sec;
    logic [63:0] r_count;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [63:0] r_dig_hi;
    logic [63:0] r_dig_lo;
    logic        r_ovalid;
    logic [127:0] r_odata;
    logic [63:0] count_inc;

    assign o_pop     = (r_state == S_IDLE) && i_head_valid;
    assign o_req     = r_req;
    assign o_valid   = r_ovalid;
    assign o_data    = r_odata;
    assign count_inc = r_count + 64'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_req.start <= 1'b0;
            r_ovalid    <= 1'b0;
            r_fnv       <= FNV_BASIS;
            r_sec       <= SEC_BASIS;
            r_count     <= '0;
        end else begin
            r_req.start <= 1'b0;
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_head_valid) begin
                        r_byte <= i_head.data_byte;
                        r_last <= i_head.last;
                        if (i_head.has_byte) begin
                            r_req   <= '{1'b1, r_sec ^ {56'd0, i_head.data_byte}, SEC_MULT};
                            r_state <= S_SEC;
                        end else begin
                            r_req   <= '{1'b1, r_count, GOLD_GAMMA};
                            r_state <= S_GAM;
                        end
                    end
                end
                S_SEC: begin
                    if (i_rsp.done) begin
                        r_sec   <= i_rsp.prod;
                        r_req   <= '{1'b1, r_fnv ^ {56'd0, r_byte}, FNV_PRIME};
                        r_state <= S_FNV;
                    end
                end
                S_FNV: begin
                    if (i_rsp.done) begin
                        r_fnv   <= i_rsp.prod;
                        r_count <= count_inc;
                        if (r_last) begin
                            r_req   <= '{1'b1, count_inc, GOLD_GAMMA};
                            r_state <= S_GAM;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_GAM: begin
                    if (i_rsp.done) begin
                        r_req   <= '{1'b1, xor_shr(r_sec + i_rsp.prod, MIX_S1), MIX_K1};
                        r_state <= S_H1;
                    end
                end
                S_H1: begin
                    if (i_rsp.done) begin
                        r_req   <= '{1'b1, xor_shr(i_rsp.prod, MIX_S2), MIX_K2};
                        r_state <= S_H2;
                    end
                end
                S_H2: begin
                    if (i_rsp.done) begin
                        r_dig_hi <= xor_shr(i_rsp.prod, MIX_S3);
                        r_req    <= '{1'b1, xor_shr(r_fnv ^ r_count, MIX_S1), MIX_K1};
                        r_state  <= S_L1;
                    end
                end
                S_L1: begin
                    if (i_rsp.done) begin
                        r_req   <= '{1'b1, xor_shr(i_rsp.prod, MIX_S2), MIX_K2};
                        r_state <= S_L2;
                    end
                end
                S_L2: begin
                    if (i_rsp.done) begin
                        r_dig_lo <= xor_shr(i_rsp.prod, MIX_S3);
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {r_dig_lo, r_dig_hi};
                        r_fnv    <= FNV_BASIS;
                        r_sec    <= SEC_BASIS;
                        r_count  <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/dual_lane_fnv_digest.sv
// Dual-lane FNV digest, top level: front queue, lane/finalizer sequencer, multiplier.
// Depends on dlfd_pkg, dlfd_front, dlfd_mul and dlfd_back.
// Each message byte takes two passes through the single shared 32x32 multiplier,
//   one per lane, and one pop; the next byte is popped only once both are done.
// A tlast transaction with a byte runs both lane updates before the finalizer; one
//   without a byte goes straight to the finalizer, then raises m_axis_tvalid.
// Reset: synchronous, active low; clears the queue, lanes, byte count and output valid.
module dual_lane_fnv_digest #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tuser,   // [0] has_byte
    input  logic         s_axis_tlast,   // last
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // [63:0] digest_high, [127:64] digest_low
);
    import dlfd_pkg::*;

    t_item    in_item;
    t_item    head;
    logic     head_valid;
    logic     pop;
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    // Pack the slave-side fields into one queue entry
    assign in_item.data_byte = s_axis_tdata;
    assign in_item.has_byte  = s_axis_tuser;
    assign in_item.last      = s_axis_tlast;

    // Front: accept each transaction, drop items that neither carry a byte nor
    // end a message, and hold the rest so the input side waits on the
    // multiplier sequence only once the queue is full.
    dlfd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_item       (in_item),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    // Shared multiplier: every lane update and every finalizer product goes here
    dlfd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // Back: advance both lanes per byte; on the last mark run the finalizer for
    // the high then the low half, then hold the digest in the output register
    // and return the lanes to their bases.
    dlfd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_req        (mul_req),
        .i_rsp        (mul_rsp),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata)
    );

endmodule

// File: rtl/dlfd_chk.sv
// Port-level checker for the dual-lane FNV digest, bound to the top level.
// Depends on dual_lane_fnv_digest ports only.
module dlfd_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    // hold a stalled digest
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("digest changed or dropped while stalled");

    // queue is empty right after reset, so input must be ready
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

    // no digest in the cycle after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("digest valid right after reset");

    // handshake outputs are always known once out of reset
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({s_axis_tready, m_axis_tvalid}))
        else $error("handshake output unknown");

endmodule

bind dual_lane_fnv_digest dlfd_chk u_dlfd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
